// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/pnq_pkg.sv -----
// ----------------------------------------------------------------------------
// pnq_pkg
// types and constants of the per-node pending request queues
// ----------------------------------------------------------------------------
package pnq_pkg;

	localparam int NODE_COUNT_DEF  = 240;
	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int NODE_W   = 8;
	localparam int TAG_W    = 16;
	localparam int SIZE_W   = 11;

	localparam logic [SIZE_W-1:0] MIN_SIZE_RST = 11'd60;

	typedef enum logic {
		OP_REQUEST  = 1'b0,
		OP_RESPONSE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STAT_ACCEPTED     = 3'd0,
		STAT_INVALID_NODE = 3'd1,
		STAT_FULL         = 3'd2,
		STAT_IGNORED      = 3'd3,
		STAT_DELIVERED    = 3'd4,
		STAT_SHORT        = 3'd5
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node_id;
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] frame_size;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  result_tag;
		logic [NODE_W-1:0] result_node;
	} out_item_t;

endpackage

// ----- sv/pnq_ptr_ram.sv -----
// ----------------------------------------------------------------------------
// pnq_ptr_ram
// per-node queue pointer memory, one entry per node, with valid bits so that
// an entry never written reads as an empty queue
// ----------------------------------------------------------------------------
module pnq_ptr_ram #(
	parameter int NODE_COUNT = 240,
	parameter int ENTRY_W    = 10,
	localparam int AW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata
);

	logic [ENTRY_W-1:0]    mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] vld_q;
	logic [ENTRY_W-1:0]    rmem_q;
	logic                  rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rmem_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rmem_q : '0;

endmodule

// ----- sv/pnq_tag_ram.sv -----
// ----------------------------------------------------------------------------
// pnq_tag_ram
// tag storage, one row per queue slot of every node, registered read
// ----------------------------------------------------------------------------
module pnq_tag_ram
	import pnq_pkg::*;
#(
	parameter int DEPTH = 1920,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [TAG_W-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [TAG_W-1:0] wdata
);

	logic [TAG_W-1:0] mem [DEPTH];
	logic [TAG_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/per_node_pending_request_queues.sv -----
// ----------------------------------------------------------------------------
// per_node_pending_request_queues
// one ring queue of pending request tags per node; requests push a tag,
// responses pop the oldest tag and grade it against a minimum frame size
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_stall        in_item  (in_item_t)
//   out      output     out_valid / out_stall      out_item (out_item_t)
//   cfg      input      cfg_we                     cfg_wdata (min size)
//
// each item passes the pointer memory read, then read-modify-write of the
// pointers with the tag memory access; a popping response then also takes
// the tag read data. one item is in flight.
// no clearing pass after reset; pointer entries carry valid bits.
// a result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in a wait state if its result is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_node_pending_request_queues
	import pnq_pkg::*;
#(
	parameter int NODE_COUNT  = NODE_COUNT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	localparam int QW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int FW     = $clog2(QUEUE_DEPTH + 1);
	localparam int EW     = 2 * PW + FW;
	localparam int TDEPTH = NODE_COUNT * QUEUE_DEPTH;
	localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FETCH,
		ST_DONE
	} state_t;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	state_t            state_q;
	logic [SIZE_W-1:0] min_q;
	in_item_t          item_s1;
	logic              ok_s1;
	logic [QW-1:0]     q_s1;
	out_item_t         res_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              acc;
	logic              node_ok;
	logic [QW-1:0]     idx_in;
	logic              out_free;
	logic              load_out;

	logic [EW-1:0]     ptr_rdata;
	logic              ptr_we;
	logic [EW-1:0]     ptr_wdata;
	logic [PW-1:0]     wp, rp;
	logic [FW-1:0]     fill;
	logic [PW-1:0]     new_wp, new_rp;
	logic [FW-1:0]     new_fill;

	logic [TAW-1:0]    tag_base;
	logic              tag_we, tag_re;
	logic [TAW-1:0]    tag_waddr, tag_raddr;
	logic [TAG_W-1:0]  tag_rdata;

	logic              pop_hit;
	status_t           look_status;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign node_ok  = (in_item.node_id != '0) && (in_item.node_id <= NODE_W'(NODE_COUNT));
	assign idx_in   = QW'(in_item.node_id - NODE_W'(1));
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = out_free && (((state_q == ST_LOOK) && !pop_hit) ||
		(state_q == ST_FETCH) || (state_q == ST_DONE));

	assign {wp, rp, fill} = ptr_rdata;
	assign tag_base       = TAW'(q_s1 * QUEUE_DEPTH);
	assign tag_waddr      = tag_base + TAW'(wp);
	assign tag_raddr      = tag_base + TAW'(rp);

	always_comb begin
		ptr_we      = 1'b0;
		tag_we      = 1'b0;
		tag_re      = 1'b0;
		pop_hit     = 1'b0;
		new_wp      = wp;
		new_rp      = rp;
		new_fill    = fill;
		look_status = STAT_IGNORED;
		if (item_s1.op == OP_REQUEST) begin
			if (!ok_s1) begin
				look_status = STAT_INVALID_NODE;
			end else if (fill >= FW'(QUEUE_DEPTH)) begin
				look_status = STAT_FULL;
			end else begin
				look_status = STAT_ACCEPTED;
				tag_we      = (state_q == ST_LOOK);
				ptr_we      = (state_q == ST_LOOK);
				new_wp      = next_ptr(wp);
				new_fill    = fill + FW'(1);
			end
		end else begin
			if (ok_s1 && (fill != '0)) begin
				look_status = (item_s1.frame_size < min_q) ? STAT_SHORT : STAT_DELIVERED;
				pop_hit     = 1'b1;
				tag_re      = (state_q == ST_LOOK);
				ptr_we      = (state_q == ST_LOOK);
				new_rp      = next_ptr(rp);
				new_fill    = fill - FW'(1);
			end
		end
	end

	assign ptr_wdata = {new_wp, new_rp, new_fill};

	pnq_ptr_ram #(
		.NODE_COUNT (NODE_COUNT),
		.ENTRY_W    (EW)
	) u_ptr_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.re    (acc && node_ok),
		.raddr (idx_in),
		.rdata (ptr_rdata),
		.we    (ptr_we),
		.waddr (q_s1),
		.wdata (ptr_wdata)
	);

	pnq_tag_ram #(
		.DEPTH (TDEPTH)
	) u_tag_ram (
		.clk   (clk),
		.re    (tag_re),
		.raddr (tag_raddr),
		.rdata (tag_rdata),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (item_s1.tag)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_SIZE_RST;
		end else if (cfg_we) begin
			min_q <= cfg_wdata;
		end
	end

	// sequencer, result holding and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			item_s1     <= '0;
			ok_s1       <= 1'b0;
			q_s1        <= '0;
			res_q       <= '0;
			out_item_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						item_s1 <= in_item;
						ok_s1   <= node_ok;
						q_s1    <= idx_in;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					res_q.status      <= look_status;
					res_q.result_tag  <= '0;
					res_q.result_node <= item_s1.node_id;
					if (pop_hit) begin
						state_q <= ST_FETCH;
					end else if (out_free) begin
						out_item_q.status      <= look_status;
						out_item_q.result_tag  <= '0;
						out_item_q.result_node <= item_s1.node_id;
						state_q                <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_FETCH: begin
					if (out_free) begin
						out_item_q.status      <= res_q.status;
						out_item_q.result_tag  <= tag_rdata;
						out_item_q.result_node <= res_q.result_node;
						state_q                <= ST_IDLE;
					end else begin
						res_q.result_tag <= tag_rdata;
						state_q          <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_item_q <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`ASSERT_IMPL(a_done_holds_out, state_q == ST_DONE, out_valid_q, "wait state without a held result")
	`ASSERT_IMPL(a_fill_bound, ptr_we, new_fill <= FW'(QUEUE_DEPTH), "fill level beyond queue depth")
	`ASSERT_IMPL(a_fetch_after_read, state_q == ST_FETCH, $past(tag_re), "tag fetch without a read")
	`ASSERT_IMPL(a_result_from_work, $rose(out_valid_q), $past(state_q != ST_IDLE), "result from idle")

endmodule
